>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes for the sorted-insert priority queue
// Operation and status codes, default sizes and the cell control group.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int TAG_BITS_DEFAULT  = 16;
  localparam int PRIO_BITS_DEFAULT = 8;

  localparam int OPCODE_BITS = 1;
  localparam int STATUS_BITS = 2;

  localparam logic [OPCODE_BITS-1:0] OP_ENQ = 1'b0;
  localparam logic [OPCODE_BITS-1:0] OP_DEQ = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

  // Broadcast to every cell: at most one of these is high in a cycle.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

>>> hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted chain
// Holds one entry. On insert it keeps its entry, takes its left neighbour's
// displaced entry, or takes the new entry; on removal it takes the right one.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEFAULT,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
  input  logic                  clk,
  input  spq_pkg::cell_ctrl_t   ctrl,
  input  logic                  occupied,
  input  logic [TAG_BITS-1:0]   new_tag,
  input  logic [PRIO_BITS-1:0]  new_prio,
  input  logic                  left_shift,
  input  logic [TAG_BITS-1:0]   left_tag,
  input  logic [PRIO_BITS-1:0]  left_prio,
  input  logic [TAG_BITS-1:0]   right_tag,
  input  logic [PRIO_BITS-1:0]  right_prio,
  output logic                  shift,
  output logic [TAG_BITS-1:0]   tag,
  output logic [PRIO_BITS-1:0]  prio
);

  // Own entry moves one place back: strictly lower than the newcomer.
  assign shift = occupied && (prio < new_prio);

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      tag  <= right_tag;
      prio <= right_prio;
    end else if (ctrl.enq && !(occupied && !shift)) begin
      // first displaced or first free slot takes the newcomer
      tag  <= left_shift ? left_tag  : new_tag;
      prio <= left_shift ? left_prio : new_prio;
    end
  end

endmodule

>>> hdl/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue - priority queue kept sorted by insertion
// Row of DEPTH cells in service order; slot 0 is the head.
// ----------------------------------------------------------------------------
// One item per clock cycle unless the output is held; the result is registered
// in the cycle after acceptance. Every cell compares its own priority with the
// newcomer in the same cycle and shifts by one place, so insertion and removal
// are a single step whatever the fill level. An enqueue goes behind all
// entries of equal or higher priority; a dequeue returns the head. Enqueue
// into a full queue answers status full, dequeue of an empty queue answers
// status empty, and the stored entries are unchanged in both cases.
module sorted_insert_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
  parameter int TAG_BITS  = spq_pkg::TAG_BITS_DEFAULT,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT,
  localparam int CNT_BITS = $clog2(DEPTH + 1),
  localparam int IN_RAW   = spq_pkg::OPCODE_BITS + TAG_BITS + PRIO_BITS,
  localparam int IN_W     = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW  = spq_pkg::STATUS_BITS + TAG_BITS + PRIO_BITS + CNT_BITS,
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // opcode, item_tag, item_priority, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status, out_tag, out_priority, entries_held, pad
);

  logic                      opcode;
  logic [TAG_BITS-1:0]       item_tag;
  logic [PRIO_BITS-1:0]      item_priority;
  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_ctrl_t       ctrl;
  logic [CNT_BITS-1:0]       count;
  logic [CNT_BITS-1:0]       count_next;
  logic [spq_pkg::STATUS_BITS-1:0] status_next;
  logic [TAG_BITS-1:0]       out_tag_next;
  logic [PRIO_BITS-1:0]      out_prio_next;

  logic [DEPTH-1:0]          cell_occ;
  logic [DEPTH-1:0]          cell_shift;
  logic [TAG_BITS-1:0]       cell_tag  [DEPTH];
  logic [PRIO_BITS-1:0]      cell_prio [DEPTH];

  assign opcode        = s_tdata[0];
  assign item_tag      = s_tdata[TAG_BITS:1];
  assign item_priority = s_tdata[TAG_BITS+PRIO_BITS:TAG_BITS+1];

  // output register frees up as soon as its item is taken
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full  = (count == CNT_BITS'(DEPTH));
  assign empty = (count == '0);

  assign ctrl.enq = accept && (opcode == spq_pkg::OP_ENQ) && !full;
  assign ctrl.deq = accept && (opcode == spq_pkg::OP_DEQ) && !empty;

  always_comb begin
    count_next    = count;
    status_next   = spq_pkg::STATUS_DONE;
    out_tag_next  = '0;
    out_prio_next = '0;
    if (opcode == spq_pkg::OP_ENQ) begin
      if (full) begin
        status_next = spq_pkg::STATUS_FULL;
      end else begin
        count_next = count + CNT_BITS'(1);
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::STATUS_EMPTY;
      end else begin
        count_next    = count - CNT_BITS'(1);
        out_tag_next  = cell_tag[0];
        out_prio_next = cell_prio[0];
      end
    end
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 l_shift;
      logic [TAG_BITS-1:0]  l_tag;
      logic [PRIO_BITS-1:0] l_prio;
      logic [TAG_BITS-1:0]  r_tag;
      logic [PRIO_BITS-1:0] r_prio;

      assign cell_occ[i] = (CNT_BITS'(i) < count);

      if (i == 0) begin : g_head
        assign l_shift = 1'b0;
        assign l_tag   = item_tag;
        assign l_prio  = item_priority;
      end else begin : g_mid_l
        assign l_shift = cell_shift[i-1];
        assign l_tag   = cell_tag[i-1];
        assign l_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_tag  = cell_tag[i];
        assign r_prio = cell_prio[i];
      end else begin : g_mid_r
        assign r_tag  = cell_tag[i+1];
        assign r_prio = cell_prio[i+1];
      end

      spq_cell #(
        .TAG_BITS  (TAG_BITS),
        .PRIO_BITS (PRIO_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (cell_occ[i]),
        .new_tag    (item_tag),
        .new_prio   (item_priority),
        .left_shift (l_shift),
        .left_tag   (l_tag),
        .left_prio  (l_prio),
        .right_tag  (r_tag),
        .right_prio (r_prio),
        .shift      (cell_shift[i]),
        .tag        (cell_tag[i]),
        .prio       (cell_prio[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_W'({count_next, out_prio_next, out_tag_next, status_next});
    end
  end

endmodule
